FILE: hdl/tks_pkg.sv
// shared types and constants for the top-k score selector
`timescale 1ns / 1ps

package tks_pkg;

    localparam int TKS_CAPACITY = 16;
    localparam int KLIM_W       = 5;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_DRAIN  = 2'd2;

    localparam logic REG_K_LIMIT = 1'b0;

    localparam logic [KLIM_W-1:0] K_LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        record_id;
        logic signed [31:0] score;
        logic signed [31:0] bound;
    } t_in_req;

    typedef struct packed {
        logic [31:0]        out_record_id;
        logic signed [31:0] out_score;
        logic               top_k_ready;
        logic               last;
    } t_out_req;

    typedef struct packed {
        logic [31:0]        id;
        logic signed [31:0] score;
    } t_pair;

    typedef struct packed {
        logic               ins;
        logic               drain;
        t_pair              new_pair;
        logic signed [31:0] bound;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

FILE: hdl/tks_cell.sv
// one cell of the sorted chain: holds one pair, shifts right on insert, left on drain
`timescale 1ns / 1ps

module tks_cell
    import tks_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  logic      i_ge_left,
    input  t_pair     i_left,
    input  t_pair     i_right,
    output t_pair     o_pair,
    output logic      o_ge,
    output logic      o_ge_bound
);

    t_pair r_pair;
    t_pair n_pair;

    assign o_ge       = i_valid && (r_pair.score >= i_ctl.new_pair.score);
    assign o_ge_bound = r_pair.score >= i_ctl.bound;
    assign o_pair     = r_pair;

    always_comb begin
        n_pair = r_pair;
        if (i_ctl.drain) begin
            n_pair = i_right;
        end else if (i_ctl.ins && !o_ge) begin
            n_pair = i_ge_left ? i_ctl.new_pair : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

endmodule

FILE: hdl/top_k_score_selector_top.sv
// top level of the top-k score selector: request channels, register port, cell chain
`timescale 1ns / 1ps
//
// Keeps the best k (record id, score) pairs in a sorted chain of cells.
// Input channel i_in_valid / o_in_stall / i_in_data carries one request:
// insert a pair, check readiness against a bound, or drain the held pairs.
// Output channel o_out_valid / i_out_stall / o_out_data carries results
// through one output register.
// An insert gives no result; inserts are taken back to back, one per
// cycle while no drain is in progress, since every cell compares against
// the new score in parallel and the whole chain shifts at once.
// A check result is in the output register in the cycle after its request.
// A drain of n pairs gives n results, one per cycle while the receiver
// does not stall, from the drain state that the request enters; the chain
// shifts toward cell 0 each time cell 0 is handed out. New requests are
// held off for the whole drain.
// While the output register is full and stalled, checks and drains wait;
// inserts still go through.
// Reset empties the store and sets k_limit to 16. The user must write k_limit over
// the APB-style port, byte address 0, only while no request is in flight; unchecked.
//

module top_k_score_selector_top
    import tks_pkg::*;
#(
    parameter int CAPACITY = TKS_CAPACITY
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_req            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_req           o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > KLIM_W) ? CW : KLIM_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [KLIM_W-1:0] r_k_limit;
    logic              r_out_valid, n_out_valid;
    t_out_req          r_out_data, n_out_data;

    t_cell_ctl         cell_ctl;
    t_pair             pairs [CAPACITY];
    logic [CAPACITY-1:0] cell_valid, cell_ge, cell_geb;

    logic          out_free, accept, ins_ok, count_lt_lim, all_ge, all_geb, ready;
    logic          drain_step;
    logic [LW-1:0] lim;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_K_LIMIT) ?
                    PDATA_W'(r_k_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_limit <= K_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[PADDR_W-1] == REG_K_LIMIT) begin
            r_k_limit <= pwdata[KLIM_W-1:0];
        end
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) ||
                        (!out_free && i_in_data.mode != MODE_INSERT);
    assign accept     = i_in_valid && !o_in_stall;

    // limit and chain summaries
    assign lim = (LW'(r_k_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(r_k_limit);
    assign count_lt_lim = LW'(r_count) < lim;
    assign all_ge  = &(~cell_valid | cell_ge);
    assign all_geb = &(~cell_valid | cell_geb);
    assign ins_ok  = count_lt_lim || (r_count != '0 && !all_ge);
    assign ready   = (r_count != '0) && (LW'(r_count) == lim) && all_geb;

    assign drain_step = (r_state == ST_DRAIN) && out_free;

    assign cell_ctl.ins      = accept && i_in_data.mode == MODE_INSERT && ins_ok;
    assign cell_ctl.drain    = drain_step;
    assign cell_ctl.new_pair = '{id: i_in_data.record_id, score: i_in_data.score};
    assign cell_ctl.bound    = i_in_data.bound;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        assign cell_valid[gi] = r_count > CW'(gi);
        tks_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_valid    (cell_valid[gi]),
            .i_ge_left  ((gi == 0) ? 1'b1 : cell_ge[(gi == 0) ? 0 : gi - 1]),
            .i_left     (pairs[(gi == 0) ? 0 : gi - 1]),
            .i_right    (pairs[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .o_pair     (pairs[gi]),
            .o_ge       (cell_ge[gi]),
            .o_ge_bound (cell_geb[gi])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_data.mode)
                        MODE_INSERT: begin
                            if (count_lt_lim) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_CHECK: begin
                            n_out_valid = 1'b1;
                            n_out_data  = '{out_record_id: '0, out_score: '0,
                                            top_k_ready: ready, last: 1'b1};
                        end
                        MODE_DRAIN: begin
                            if (r_count != '0) begin
                                n_state = ST_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (drain_step) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{out_record_id: pairs[0].id,
                                    out_score: pairs[0].score,
                                    top_k_ready: 1'b0,
                                    last: r_count == CW'(1)};
                    n_count     = r_count - 1'b1;
                    if (r_count == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> r_count != '0)
        else $error("drain with empty store");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_step && r_count == CW'(1) |=>
            r_state == ST_IDLE && r_count == '0 && o_out_valid && o_out_data.last)
        else $error("drain did not end on last");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.ins && count_lt_lim |=> r_count == $past(r_count) + 1'b1)
        else $error("insert below limit did not grow count");

endmodule

FILE: bench/tb_top.sv
// testbench for the top-k score selector: random and directed requests checked against a ranking model
`timescale 1ns / 1ps

module tb_top;
    import tks_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int CFG_SETTLE      = 8;
    localparam int DRAIN_TAIL      = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 18;

    localparam logic [1:0]         MODE_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] K_LIMIT_ADDR = PADDR_W'(REG_K_LIMIT) << 2;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE   = 32'sh0001_0000;

    class ranking_tracker;
        logic signed [31:0] held_score [TKS_CAPACITY];
        logic [31:0]        held_id [TKS_CAPACITY];
        int unsigned        held_n;
        int unsigned        k_lim;
        t_out_req           pending_results [$];
        int                 errors;

        function new();
            held_n = 0;
            k_lim  = K_LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [KLIM_W-1:0] value);
            k_lim = value;
        endfunction

        function int unsigned active_limit();
            return (k_lim > TKS_CAPACITY) ? TKS_CAPACITY : k_lim;
        endfunction

        function logic signed [31:0] lowest_held();
            if (held_n == 0) begin
                return '0;
            end
            return held_score[held_n - 1];
        endfunction

        // ties stay in insertion order: new pair goes after every score >= its own
        function void place_pair(logic [31:0] id, logic signed [31:0] s);
            int unsigned pos;
            if (held_n >= TKS_CAPACITY) begin
                return;
            end
            pos = 0;
            while (pos < held_n && held_score[pos] >= s) begin
                pos++;
            end
            for (int unsigned i = held_n; i > pos; i--) begin
                held_score[i] = held_score[i - 1];
                held_id[i]    = held_id[i - 1];
            end
            held_score[pos] = s;
            held_id[pos]    = id;
            held_n++;
        endfunction

        function void note_request(t_in_req r);
            logic signed [31:0] s;
            logic signed [31:0] b;
            t_out_req           e;
            s = r.score;
            b = r.bound;
            case (r.mode)
                MODE_INSERT: begin
                    if (held_n < active_limit()) begin
                        place_pair(r.record_id, s);
                    end else if (held_n != 0) begin
                        if (s > held_score[held_n - 1]) begin
                            held_n--;
                            place_pair(r.record_id, s);
                        end
                    end
                end
                MODE_CHECK: begin
                    e = '0;
                    e.last = 1'b1;
                    if (held_n != 0 && held_n == active_limit()) begin
                        e.top_k_ready = (held_score[held_n - 1] >= b);
                    end
                    pending_results.push_back(e);
                end
                MODE_DRAIN: begin
                    for (int unsigned i = 0; i < held_n; i++) begin
                        e = '0;
                        e.out_record_id = held_id[i];
                        e.out_score     = held_score[i];
                        e.last          = (i + 1 == held_n);
                        pending_results.push_back(e);
                    end
                    held_n = 0;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_out_req got);
            t_out_req e;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: out_record_id %h out_score %0d",
                       got.out_record_id, got.out_score);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (got.out_record_id !== e.out_record_id) begin
                $error("out_record_id: expected %h, got %h", e.out_record_id, got.out_record_id);
                errors++;
            end
            if (got.out_score !== e.out_score) begin
                $error("out_score: expected %0d, got %0d", e.out_score, got.out_score);
                errors++;
            end
            if (got.top_k_ready !== e.top_k_ready) begin
                $error("top_k_ready: expected %b, got %b", e.top_k_ready, got.top_k_ready);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %b, got %b", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_req            i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_req           o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ranking_tracker sb;
    bit             in_quiet;
    bit             out_quiet;
    int             out_hold;
    int             idle_cycles;

    top_k_score_selector_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int unsigned roll;
        if (quiet) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [31:0] pick_score();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return (int'($urandom_range(0, 8)) - 4) * 65536;
            2: begin
                case ($urandom_range(0, 3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return int'(16'($urandom)) - 32768;
        endcase
    endfunction

    task automatic issue(logic [1:0] mode, logic [31:0] id, logic signed [31:0] score,
                         logic signed [31:0] bound);
        t_in_req r;
        int      gap;
        r.mode      = mode;
        r.record_id = id;
        r.score     = score;
        r.bound     = bound;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(r);
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic configure(logic [KLIM_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        // an insert may still be settling in the chain
        repeat (CFG_SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= K_LIMIT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.set_limit(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== PDATA_W'(value)) begin
            $error("k_limit: expected %0d, got %0d", value, readback);
            sb.errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            idle_cycles <= 0;
            out_hold = 0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (out_hold != 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else begin
                i_out_stall <= 1'b0;
                out_hold = pick_gap(out_quiet);
            end
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [KLIM_W-1:0]  phase_limit [NUM_PHASES];
        int unsigned        roll;
        logic [1:0]         mode;
        logic signed [31:0] bound;

        sb = new();
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        phase_limit = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd2, 5'd16, 5'd9, 5'd0};
        phase_limit[NUM_PHASES - 1] = KLIM_W'($urandom_range(0, 31));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, unused mode, extremes and a tie
        issue(MODE_CHECK, 32'h0, 32'sh0, S_MIN);
        issue(MODE_DRAIN, 32'h0, 32'sh0, 32'sh0);
        issue(MODE_UNUSED, 32'hFFFF_FFFF, S_MAX, S_MAX);
        issue(MODE_INSERT, 32'hFFFF_FFFF, S_MAX, 32'sh0);
        issue(MODE_INSERT, 32'h0, S_MIN, S_MAX);
        issue(MODE_INSERT, 32'h1234_5678, 32'sh0, 32'sh0);
        issue(MODE_INSERT, 32'h9ABC_DEF0, 32'sh0, 32'sh0);
        issue(MODE_CHECK, 32'h0, 32'sh0, S_MIN);
        issue(MODE_DRAIN, 32'h0, 32'sh0, 32'sh0);

        // zero limit
        configure(5'd0);
        issue(MODE_INSERT, 32'h55, ONE, 32'sh0);
        issue(MODE_CHECK, 32'h0, 32'sh0, S_MIN);

        // full store, bottom ties, eviction of the newest tie
        configure(5'd3);
        issue(MODE_INSERT, 32'hA, 5 * ONE, 32'sh0);
        issue(MODE_INSERT, 32'hB, 3 * ONE, 32'sh0);
        issue(MODE_INSERT, 32'hC, 3 * ONE, 32'sh0);
        issue(MODE_CHECK, 32'h0, 32'sh0, 3 * ONE);
        issue(MODE_INSERT, 32'hD, 4 * ONE, 32'sh0);
        issue(MODE_INSERT, 32'hE, 3 * ONE, 32'sh0);
        issue(MODE_CHECK, 32'h0, 32'sh0, 4 * ONE);

        // limit lowered below the held count
        configure(5'd1);
        issue(MODE_INSERT, 32'hF, 9 * ONE, 32'sh0);
        issue(MODE_CHECK, 32'h0, 32'sh0, S_MIN);
        issue(MODE_DRAIN, 32'h0, 32'sh0, 32'sh0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(phase_limit[p]);
            in_quiet  = (p % 3 == 2);
            out_quiet = (p % 4 == 1);
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    mode = MODE_INSERT;
                end else if (roll < 87) begin
                    mode = MODE_CHECK;
                end else if (roll < 94) begin
                    mode = MODE_DRAIN;
                end else begin
                    mode = MODE_UNUSED;
                end
                if (sb.held_n != 0 && $urandom_range(0, 9) < 4) begin
                    bound = sb.lowest_held() + (int'($urandom_range(0, 2)) - 1);
                end else begin
                    bound = pick_score();
                end
                issue(mode, $urandom, pick_score(), bound);
            end
            if ($urandom_range(0, 2) != 0) begin
                issue(MODE_DRAIN, $urandom, pick_score(), pick_score());
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tks_pkg.sv
hdl/tks_cell.sv
hdl/top_k_score_selector_top.sv
bench/tb_top.sv
